// ===== sv/fmcem_pkg.sv =====
// shared types, constants and envelope helper functions for the fm envelope mixer
package fmcem_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int CH_W = $clog2(NUM_CHANNELS);
	localparam int LEVEL_W = 26;
	localparam int RATE_W = 14;
	localparam int TARGET_W = 25;
	localparam int FMULT_W = 13;
	localparam logic [FMULT_W-1:0] FMULT_RESET = FMULT_W'(2455);

	// item kinds carried in tuser
	localparam logic [1:0] OP_PORT = 2'd0;
	localparam logic [1:0] OP_RELOAD = 2'd1;
	localparam logic [1:0] OP_RENDER = 2'd2;

	// register indexes
	localparam logic [7:0] REG_KEY = 8'h28;
	localparam logic [3:0] REG_NOTE_HI = 4'ha;
	localparam logic [3:0] REG_ATTACK_HI = 4'h5;
	localparam logic [3:0] REG_RELEASE_HI = 4'h8;

	// envelope phases
	localparam logic [2:0] ENV_IDLE = 3'd0;
	localparam logic [2:0] ENV_ATTACK = 3'd1;
	localparam logic [2:0] ENV_DECAY = 3'd2;
	localparam logic [2:0] ENV_SUSTAIN = 3'd3;
	localparam logic [2:0] ENV_RELEASE = 3'd4;

	// rendered channel walk: 0,1,2,4,5,6
	localparam logic [CH_W-1:0] CH_FIRST = CH_W'(0);
	localparam logic [CH_W-1:0] CH_BEFORE_GAP = CH_W'(2);
	localparam logic [CH_W-1:0] CH_AFTER_GAP = CH_W'(4);
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(6);

	localparam logic [TARGET_W-1:0] ATTACK_TARGET = TARGET_W'(25'h1000000);

	typedef struct packed {
		logic wr;
		logic mul;
		logic reload;
		logic step;
		logic out_load;
		logic [CH_W-1:0] ch;
	} cmd_t;

	typedef struct packed {
		logic need_mul;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic signed [RATE_W-1:0] rate;
		logic [TARGET_W-1:0] target;
	} env_t;

	// rate code from a five-bit rate field
	function automatic logic [5:0] rate_code(input logic [7:0] r);
		logic [5:0] c;
		c = {1'b0, r[4:0]};
		if (c != 6'd0) c = c + 6'd16;
		return c;
	endfunction

	// rate and target for an envelope phase; idle keeps the old values
	function automatic env_t env_load(input logic [2:0] ph, input logic [7:0] r_atk,
			input logic [7:0] r_dec, input logic [7:0] r_sus, input logic [7:0] r_rel,
			input env_t cur);
		env_t e;
		logic [5:0] rr;
		e = cur;
		rr = {1'b0, r_rel[3:0], 1'b0} + 6'd16;
		case (ph)
			ENV_ATTACK: begin
				e.rate = $signed({1'b0, rate_code(r_atk), 7'b0});
				e.target = ATTACK_TARGET;
			end
			ENV_DECAY: begin
				e.rate = -$signed({3'b0, rate_code(r_dec), 5'b0});
				e.target = '0;
			end
			ENV_SUSTAIN: begin
				e.rate = -$signed({3'b0, rate_code(r_sus), 5'b0});
				e.target = {1'b0, r_rel[7:4], 20'b0};
			end
			ENV_RELEASE: begin
				e.rate = -$signed({3'b0, rr, 5'b0});
				e.target = '0;
			end
			default: e = cur;
		endcase
		return e;
	endfunction

endpackage

// ===== sv/fmcem_ctrl.sv =====
// controller state machine: sequences port writes, envelope reloads and channel steps
module fmcem_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [1:0] in_op,
	output logic in_ready,
	input  fmcem_pkg::stat_t stat,
	output fmcem_pkg::cmd_t cmd
);
	import fmcem_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WRITE = 3'd1;
	localparam logic [2:0] S_MUL = 3'd2;
	localparam logic [2:0] S_RELOAD = 3'd3;
	localparam logic [2:0] S_RENDER = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [2:0] state_q, state_d;
	logic [CH_W-1:0] ch_q, ch_d, ch_next;

	assign in_ready = (state_q == S_IDLE);
	assign ch_next = (ch_q == CH_BEFORE_GAP) ? CH_AFTER_GAP : ch_q + CH_W'(1);

	// next state and commands
	always_comb begin
		state_d = state_q;
		ch_d = ch_q;
		cmd = '0;
		cmd.ch = ch_q;
		unique case (state_q)
			S_IDLE: begin
				ch_d = CH_FIRST;
				if (in_valid) begin
					unique case (in_op)
						OP_PORT: state_d = S_WRITE;
						OP_RELOAD: state_d = S_RELOAD;
						OP_RENDER: state_d = S_RENDER;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_WRITE: begin
				cmd.wr = 1'b1;
				state_d = stat.need_mul ? S_MUL : S_IDLE;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_IDLE;
			end
			S_RELOAD: begin
				cmd.reload = 1'b1;
				ch_d = ch_next;
				if (ch_q == CH_LAST) state_d = S_IDLE;
			end
			S_RENDER: begin
				cmd.step = 1'b1;
				ch_d = ch_next;
				if (ch_q == CH_LAST) state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q <= CH_FIRST;
		end else begin
			state_q <= state_d;
			ch_q <= ch_d;
		end
	end

endmodule

// ===== sv/fmcem_datapath.sv =====
// datapath: register bytes, channel state, phase step multiplier, envelope and mixer
module fmcem_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [fmcem_pkg::FMULT_W-1:0] cfg_value,
	input  logic in_accept,
	input  logic [1:0] in_port,
	input  logic [7:0] in_value,
	input  fmcem_pkg::cmd_t cmd,
	output fmcem_pkg::stat_t stat,
	output logic out_valid,
	input  logic out_ready,
	output logic [15:0] out_sample
);
	import fmcem_pkg::*;

	logic [FMULT_W-1:0] fmult_q;
	logic [1:0] port_q;
	logic [7:0] value_q;
	logic [7:0] idx_q [2];
	// only the envelope bytes are ever read back: 0x50/60/70/80 + channel offset
	logic [7:0] envreg_q [4][NUM_CHANNELS];
	logic [15:0] phase_q [NUM_CHANNELS];
	logic [15:0] pstep_q [NUM_CHANNELS];
	logic [15:0] note_q [NUM_CHANNELS];
	logic [2:0] ephase_q [NUM_CHANNELS];
	logic signed [LEVEL_W-1:0] level_q [NUM_CHANNELS];
	env_t env_q [NUM_CHANNELS];
	logic [CH_W-1:0] wch_q;
	logic signed [15:0] acc_q;
	logic out_valid_q;
	logic [15:0] out_data_q;

	// port write decode
	logic bank;
	logic [7:0] idx;
	logic [CH_W-1:0] wch;
	logic envreg_hit;
	logic [1:0] envreg_sel;
	assign bank = port_q[1];
	assign idx = idx_q[bank];
	assign wch = {bank, idx[1:0]};
	assign envreg_hit = (idx[7:4] >= REG_ATTACK_HI) && (idx[7:4] <= REG_RELEASE_HI)
		&& (idx[3:2] == 2'b00);
	assign envreg_sel = 2'(idx[7:4] - REG_ATTACK_HI);
	assign stat.need_mul = port_q[0] && (idx[7:4] == REG_NOTE_HI);
	assign stat.out_free = !out_valid_q || out_ready;

	// phase step multiply: note fraction shifted by block, times freq_mult
	logic [17:0] fnum_sh;
	logic [31:0] prod;
	assign fnum_sh = {7'b0, note_q[wch_q][10:0]} << note_q[wch_q][13:11];
	assign prod = 32'(fnum_sh) * 32'(fmult_q);

	// selected channel for reload and step
	logic [CH_W-1:0] c;
	env_t env_rel;
	assign c = cmd.ch;
	assign env_rel = env_load(ephase_q[c], envreg_q[0][c], envreg_q[1][c],
		envreg_q[2][c], envreg_q[3][c], env_q[c]);

	// channel contribution and saturated mix
	logic signed [17:0] lvl_sh;
	logic signed [18:0] dn;
	logic signed [13:0] contrib;
	logic signed [17:0] mix_sum;
	logic signed [15:0] mix_sat;
	assign lvl_sh = 18'(level_q[c] >>> 8);
	assign dn = phase_q[c][15] ? -19'(lvl_sh) : 19'(lvl_sh);
	assign contrib = 14'(dn >>> 5);
	assign mix_sum = 18'(acc_q) + 18'(contrib);
	always_comb begin
		if (mix_sum > 18'sd32767) mix_sat = 16'sh7fff;
		else if (mix_sum < -18'sd32768) mix_sat = -16'sh8000;
		else mix_sat = 16'(mix_sum);
	end

	// envelope level update and phase transitions
	logic signed [LEVEL_W:0] lv_sum, tgt_x;
	logic signed [LEVEL_W-1:0] lv_sat, lv_new;
	logic [2:0] ph_new;
	logic ph_move;
	env_t env_new;
	assign lv_sum = (LEVEL_W+1)'(level_q[c]) + (LEVEL_W+1)'(env_q[c].rate);
	assign tgt_x = $signed({2'b00, env_q[c].target});
	always_comb begin
		if (lv_sum > (LEVEL_W+1)'(26'sh1ffffff)) lv_sat = 26'sh1ffffff;
		else if (lv_sum < -(LEVEL_W+1)'(27'sh2000000)) lv_sat = -26'sh2000000;
		else lv_sat = LEVEL_W'(lv_sum);
		lv_new = lv_sat;
		ph_new = ephase_q[c];
		ph_move = 1'b0;
		case (ephase_q[c])
			ENV_ATTACK: begin
				if ((LEVEL_W+1)'(lv_sat) >= tgt_x) begin
					lv_new = LEVEL_W'(tgt_x);
					ph_new = ENV_DECAY;
					ph_move = 1'b1;
				end
			end
			ENV_DECAY, ENV_SUSTAIN: begin
				if ((LEVEL_W+1)'(lv_sat) < tgt_x) begin
					lv_new = LEVEL_W'(tgt_x);
					ph_new = ephase_q[c] + 3'd1;
					ph_move = 1'b1;
				end
			end
			ENV_RELEASE: begin
				if ((LEVEL_W+1)'(lv_sat) < tgt_x) lv_new = LEVEL_W'(tgt_x);
			end
			default: ;
		endcase
		env_new = ph_move ? env_load(ph_new, envreg_q[0][c], envreg_q[1][c],
			envreg_q[2][c], envreg_q[3][c], env_q[c]) : env_q[c];
	end

	// item capture and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmult_q <= FMULT_RESET;
			port_q <= '0;
			value_q <= '0;
			acc_q <= '0;
		end else begin
			if (cfg_we) fmult_q <= cfg_value;
			if (in_accept) begin
				port_q <= in_port;
				value_q <= in_value;
				acc_q <= '0;
			end else if (cmd.step) begin
				acc_q <= mix_sat;
			end
		end
	end

	// register writes, reloads and channel steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '{default: '0};
			envreg_q <= '{default: '{default: '0}};
			phase_q <= '{default: '0};
			pstep_q <= '{default: '0};
			note_q <= '{default: '0};
			ephase_q <= '{default: ENV_IDLE};
			level_q <= '{default: '0};
			env_q <= '{default: '0};
			wch_q <= '0;
		end else begin
			if (cmd.wr) begin
				if (!port_q[0]) begin
					idx_q[bank] <= value_q;
				end else begin
					if (idx == REG_KEY)
						ephase_q[value_q[CH_W-1:0]] <= (|value_q[7:4]) ? ENV_ATTACK
							: ENV_RELEASE;
					if (envreg_hit) envreg_q[envreg_sel][wch] <= value_q;
					if (idx[7:4] == REG_NOTE_HI) begin
						wch_q <= wch;
						if (idx[2]) note_q[wch] <= {value_q, 8'h00};
						else note_q[wch] <= note_q[wch] | {8'h00, value_q};
					end
				end
			end
			if (cmd.mul) pstep_q[wch_q] <= prod[31:16];
			if (cmd.reload) env_q[c] <= env_rel;
			if (cmd.step) begin
				phase_q[c] <= phase_q[c] + pstep_q[c];
				level_q[c] <= lv_new;
				ephase_q[c] <= ph_new;
				env_q[c] <= env_new;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
			out_data_q <= acc_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_sample = out_data_q;

endmodule

// ===== sv/fm_channel_envelope_mixer_unit.sv =====
// top level of the fm channel envelope mixer: controller plus datapath
//
// channel   dir  signals                          contents
// s_axis    in   tvalid tready tdata[15:0] tuser  port, value / op
// m_axis    out  tvalid tready tdata[15:0]        mixed sample
// cfg       in   valid ready data[12:0]           freq_mult
//
// one item at a time: a port write passes the write state, plus the phase step
// multiplier state when it retunes a channel; an envelope reload steps each
// rendered channel; a render runs accept, one channel per cycle through
// the shared envelope and mix unit, and output load, where it waits while the
// output register is still full. reset clears all state at once, no sweep.
module fm_channel_envelope_mixer_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // port[1:0], value[9:2], zero fill
	input  logic [1:0] s_axis_tuser,   // op[1:0]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [15:0] m_axis_tdata,  // sample[15:0]
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [12:0] cfg_data       // freq_mult[12:0]
);
	import fmcem_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic in_accept;

	assign cfg_ready = 1'b1;
	assign in_accept = s_axis_tvalid && s_axis_tready;

	fmcem_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_op(s_axis_tuser),
		.in_ready(s_axis_tready),
		.stat(stat),
		.cmd(cmd)
	);

	fmcem_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_value(cfg_data),
		.in_accept(in_accept),
		.in_port(s_axis_tdata[1:0]),
		.in_value(s_axis_tdata[9:2]),
		.cmd(cmd),
		.stat(stat),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_sample(m_axis_tdata)
	);

	// one item in flight: no transfer right after a transfer that starts work
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (s_axis_tuser == OP_PORT || s_axis_tuser == OP_RELOAD
			|| s_axis_tuser == OP_RENDER)) |=> !s_axis_tready)
		else $error("input taken while an item is in flight");

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output register overwritten");

	// channels 3 and 7 are never stepped or reloaded
	a_skip_ch: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.reload) |-> (cmd.ch != 3'd3 && cmd.ch != 3'd7))
		else $error("unrendered channel stepped");

endmodule
